@@ hdl/svc_pkg.sv @@
// svc_pkg: shared types, codes and reset values for the string voicer.
// Used by svc_fade_alu, svc_out_reg and strum_zone_string_voicer.
`timescale 1ns / 1ps

package svc_pkg;

    localparam int NUM_STRINGS_DEF = 6;
    localparam int NUM_CHORDS      = 6;

    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int STAT_W  = 8;
    localparam int ZONE_W  = 3;
    localparam int CFG_IW  = 3;
    localparam int TDATA_W = 24;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_CHORD_LAST = 3'd5;
    localparam logic [CFG_IW-1:0] REG_FADE       = 3'd6;

    localparam logic [NOTE_W-1:0] CHORD_RESET [NUM_CHORDS] =
        '{7'd43, 7'd47, 7'd50, 7'd55, 7'd59, 7'd67};
    localparam logic [VEL_W-1:0]  FADE_RESET = 7'd4;

    // emitted status codes
    localparam logic [STAT_W-1:0] ST_NOTE_OFF = 8'h80;
    localparam logic [STAT_W-1:0] ST_NOTE_ON  = 8'h90;
    localparam logic [STAT_W-1:0] ST_POLY_AT  = 8'hA0;

    // incoming message types (high nibble)
    localparam logic [3:0] MSG_NOTE_ON = 4'h9;
    localparam logic [3:0] MSG_CC      = 4'hB;
    localparam logic [6:0] CC_STRUM    = 7'd1;

    localparam logic       OP_MIDI = 1'b0;
    localparam logic       OP_FADE = 1'b1;

    localparam logic [VEL_W-1:0]  VEL_MAX   = 7'd127;
    localparam logic [ZONE_W-1:0] ZONE_NONE = 3'd7;

    localparam logic [6:0] ZONE_B0 = 7'd24;
    localparam logic [6:0] ZONE_B1 = 7'd44;
    localparam logic [6:0] ZONE_B2 = 7'd64;
    localparam logic [6:0] ZONE_B3 = 7'd84;
    localparam logic [6:0] ZONE_B4 = 7'd104;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic              last;
    } t_result;

    function automatic logic [ZONE_W-1:0] zone_of(input logic [6:0] v);
        logic [ZONE_W-1:0] z;
        if (v < ZONE_B0)      z = 3'd0;
        else if (v < ZONE_B1) z = 3'd1;
        else if (v < ZONE_B2) z = 3'd2;
        else if (v < ZONE_B3) z = 3'd3;
        else if (v < ZONE_B4) z = 3'd4;
        else                  z = 3'd5;
        return z;
    endfunction

endpackage

@@ hdl/svc_fade_alu.sv @@
// svc_fade_alu: shared decrement and compare unit for the fade sweep.
// Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_fade_alu (
    input  logic [svc_pkg::VEL_W-1:0] i_vel,
    input  logic [svc_pkg::VEL_W-1:0] i_step,
    output logic                      o_above,
    output logic [svc_pkg::VEL_W-1:0] o_level
);

    logic [svc_pkg::VEL_W:0] w_diff;

    assign w_diff  = {1'b0, i_vel} - {1'b0, i_step};
    // above: level stays positive after the step
    assign o_above = !w_diff[svc_pkg::VEL_W] && (w_diff[svc_pkg::VEL_W-1:0] != '0);
    assign o_level = o_above ? w_diff[svc_pkg::VEL_W-1:0] : '0;

endmodule

@@ hdl/svc_out_reg.sv @@
// svc_out_reg: single result register on the master stream side.
// Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  svc_pkg::t_result              i_res,
    output logic                          o_can_push,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [svc_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast
);

    logic             r_valid;
    svc_pkg::t_result r_res;

    assign o_can_push = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_push && i_push) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_res.vel, r_res.note, r_res.status};
    assign m_axis_tlast  = r_res.last;

endmodule

@@ hdl/strum_zone_string_voicer.sv @@
// strum_zone_string_voicer: top level, string state, sequencer and config registers.
// Depends on svc_pkg, svc_fade_alu and svc_out_reg.
//
// Usage:
//   s_axis carries one item per transfer: tuser is the operation (0 MIDI message,
//   1 fade tick), tdata the MIDI status and two data bytes. m_axis returns the
//   MIDI messages caused by that item, tlast on the final one; an item may
//   cause none. The cfg channel writes chord notes 0..5 (index 0..5) and the
//   fade step (index 6); it is always ready and must be written by the user while
//   idle, which the block does not enforce. Throughput: unless m_axis stalls, one
//   string is handled per cycle by a single shared decrement unit. An accepted
//   note-on or fade tick sweeps the strings up to the highest that answers, at
//   least one step; a controller 1 zone change runs a mute and a pluck step;
//   other messages need only acceptance. Results are registered and appear in
//   the cycle after the step that makes them. s_axis_tready is low while a
//   sweep or zone change runs. Reset (synchronous, active low) silences all
//   strings, clears the last zone and loads the default chord and fade step. A
//   stall on m_axis holds the sweep on the string that waits; nothing is dropped.
`timescale 1ns / 1ps

module strum_zone_string_voicer #(
    parameter int NUM_STRINGS = svc_pkg::NUM_STRINGS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [svc_pkg::TDATA_W-1:0] s_axis_tdata, // status[7:0] data_one[14:8] data_two[21:15]
    input  logic                              s_axis_tuser,  // operation
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [svc_pkg::TDATA_W-1:0] m_axis_tdata, // status[7:0] note[14:8] velocity[21:15]
    output logic                              m_axis_tlast,
    // config write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svc_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [svc_pkg::VEL_W-1:0]         i_cfg_data
);

    localparam int IW = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_ZMUTE = 2'd2;
    localparam logic [1:0] S_PLUCK = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [IW-1:0]                   r_idx, n_idx;
    logic [NUM_STRINGS-1:0]          r_mask, n_mask;
    logic                            r_fade, n_fade;
    logic [svc_pkg::NOTE_W-1:0]      r_note, n_note;
    logic [svc_pkg::ZONE_W-1:0]      r_last_zone, n_last_zone;
    logic [svc_pkg::NOTE_W-1:0]      r_held [NUM_STRINGS];
    logic [svc_pkg::NOTE_W-1:0]      n_held [NUM_STRINGS];
    logic [svc_pkg::VEL_W-1:0]       r_vel  [NUM_STRINGS];
    logic [svc_pkg::VEL_W-1:0]       n_vel  [NUM_STRINGS];
    logic [svc_pkg::NOTE_W-1:0]      r_chord [svc_pkg::NUM_CHORDS];
    logic [svc_pkg::VEL_W-1:0]       r_step;

    logic                            w_accept;
    logic                            w_op;
    logic [svc_pkg::STAT_W-1:0]      w_status;
    logic [6:0]                      w_d1;
    logic [6:0]                      w_d2;
    logic [svc_pkg::ZONE_W-1:0]      w_zone_raw;
    logic [svc_pkg::ZONE_W-1:0]      w_zone;
    logic [NUM_STRINGS-1:0]          w_held_mask;
    logic [NUM_STRINGS-1:0]          w_fade_mask;
    logic [NUM_STRINGS-1:0]          w_rest;
    logic [svc_pkg::NOTE_W-1:0]      w_cur_note;
    logic                            w_above;
    logic [svc_pkg::VEL_W-1:0]       w_level;
    logic                            w_can_push;
    logic                            w_push;
    svc_pkg::t_result                w_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_status      = s_axis_tdata[7:0];
    assign w_d1          = s_axis_tdata[14:8];
    assign w_d2          = s_axis_tdata[21:15];
    assign o_cfg_ready   = 1'b1;

    assign w_zone_raw = svc_pkg::zone_of(w_d2);
    always_comb begin
        w_zone = w_zone_raw;
        if (32'(w_zone_raw) >= NUM_STRINGS) begin
            w_zone = svc_pkg::ZONE_W'(NUM_STRINGS - 1);
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_STRINGS; s++) begin
            w_held_mask[s] = (r_held[s] != '0);
            w_fade_mask[s] = (r_held[s] != '0) && (r_vel[s] != '0);
        end
    end

    assign w_rest     = r_mask >> 1;
    assign w_cur_note = r_held[r_idx];

    svc_fade_alu u_alu (
        .i_vel   (r_vel[r_idx]),
        .i_step  (r_step),
        .o_above (w_above),
        .o_level (w_level)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_mask      = r_mask;
        n_fade      = r_fade;
        n_note      = r_note;
        n_last_zone = r_last_zone;
        n_held      = r_held;
        n_vel       = r_vel;
        w_push      = 1'b0;
        w_res       = '{status: svc_pkg::ST_NOTE_OFF, note: w_cur_note, vel: '0, last: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    if (w_op == svc_pkg::OP_FADE) begin
                        n_mask  = w_fade_mask;
                        n_fade  = 1'b1;
                        n_state = S_SWEEP;
                    end else if (w_status[7:4] == svc_pkg::MSG_NOTE_ON) begin
                        n_mask  = w_held_mask;
                        n_fade  = 1'b0;
                        for (int s = 0; s < NUM_STRINGS; s++) begin
                            n_vel[s] = '0;
                        end
                        n_state = S_SWEEP;
                    end else if (w_status[7:4] == svc_pkg::MSG_CC &&
                                 w_d1 == svc_pkg::CC_STRUM &&
                                 w_zone != r_last_zone) begin
                        n_idx       = IW'(w_zone);
                        n_note      = r_chord[w_zone];
                        n_last_zone = w_zone;
                        n_state     = S_ZMUTE;
                    end
                end
            end
            S_SWEEP: begin
                if (!r_mask[0] || w_can_push) begin
                    if (r_mask[0]) begin
                        w_push = 1'b1;
                        if (r_fade) begin
                            n_vel[r_idx] = w_level;
                            w_res.status = w_above ? svc_pkg::ST_POLY_AT : svc_pkg::ST_NOTE_ON;
                            w_res.vel    = w_level;
                        end else begin
                            n_held[r_idx] = '0;
                        end
                    end
                    w_res.last = (w_rest == '0);
                    n_mask     = w_rest;
                    n_idx      = r_idx + IW'(1);
                    if (w_rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ZMUTE: begin
                if (w_cur_note == '0 || w_can_push) begin
                    w_push        = (w_cur_note != '0);
                    n_held[r_idx] = '0;
                    n_vel[r_idx]  = '0;
                    n_state       = S_PLUCK;
                end
            end
            S_PLUCK: begin
                w_res = '{status: svc_pkg::ST_NOTE_ON, note: r_note,
                          vel: svc_pkg::VEL_MAX, last: 1'b1};
                if (w_can_push) begin
                    w_push        = 1'b1;
                    n_held[r_idx] = r_note;
                    n_vel[r_idx]  = svc_pkg::VEL_MAX;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_zone <= svc_pkg::ZONE_NONE;
            for (int s = 0; s < NUM_STRINGS; s++) begin
                r_held[s] <= '0;
                r_vel[s]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_last_zone <= n_last_zone;
            r_held      <= n_held;
            r_vel       <= n_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_mask <= n_mask;
        r_fade <= n_fade;
        r_note <= n_note;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chord <= svc_pkg::CHORD_RESET;
            r_step  <= svc_pkg::FADE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index <= svc_pkg::REG_CHORD_LAST) begin
                r_chord[i_cfg_index] <= i_cfg_data;
            end else if (i_cfg_index == svc_pkg::REG_FADE) begin
                r_step <= i_cfg_data;
            end
        end
    end

    svc_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_res         (w_res),
        .o_can_push    (w_can_push),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/tb_strum_zone_string_voicer.sv @@
// tb_strum_zone_string_voicer: self-checking bench for the strum-zone string voicer.
// Drives MIDI messages and fade ticks, predicts every emitted message and checks it.
// Depends on svc_pkg and strum_zone_string_voicer.
`timescale 1ns / 1ps

module tb_strum_zone_string_voicer;
    import svc_pkg::*;

    localparam int                CLK_HALF     = 4;
    localparam int                SETTLE_CYCLES = NUM_STRINGS_DEF + 4;
    localparam int                STALL_LIMIT  = 3000;
    localparam int                REPORT_MAX   = 10;
    localparam logic [CFG_IW-1:0] REG_CHORD_TWO = 3'd2;
    localparam logic [CFG_IW-1:0] REG_SPARE    = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;  // status[7:0] data_one[14:8] data_two[21:15]
    logic                  s_axis_tuser  = OP_MIDI;  // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;  // out_status[7:0] out_note[14:8] out_velocity[21:15]
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IW-1:0]     i_cfg_index   = '0;
    logic [VEL_W-1:0]      i_cfg_data    = '0;

    strum_zone_string_voicer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow of the voicer
    logic [NOTE_W-1:0] chord_note   [NUM_CHORDS];
    logic [VEL_W-1:0]  fade_dec;
    logic [NOTE_W-1:0] string_note  [NUM_STRINGS_DEF];
    logic [VEL_W-1:0]  string_level [NUM_STRINGS_DEF];
    int                cur_zone;

    t_result item_msgs[$];
    t_result expected_msgs[$];

    int          mismatch_cnt = 0;
    int          burst_left   = 0;
    int          idle_cycles  = 0;
    logic [9:0]  rx_phase     = '0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void push_msg(logic [STAT_W-1:0] st, logic [NOTE_W-1:0] note,
                                     logic [VEL_W-1:0] vel);
        t_result r;
        r.status = st;
        r.note   = note;
        r.vel    = vel;
        r.last   = 1'b0;
        item_msgs.push_back(r);
    endfunction

    function automatic void silence_string(int s);
        string_level[s] = '0;
        if (string_note[s] != '0) begin
            push_msg(ST_NOTE_OFF, string_note[s], '0);
            string_note[s] = '0;
        end
    endfunction

    function automatic int zone_for(logic [6:0] v);
        int z;
        z = 0;
        if (v >= ZONE_B0) z++;
        if (v >= ZONE_B1) z++;
        if (v >= ZONE_B2) z++;
        if (v >= ZONE_B3) z++;
        if (v >= ZONE_B4) z++;
        if (z > NUM_STRINGS_DEF - 1) z = NUM_STRINGS_DEF - 1;
        return z;
    endfunction

    function automatic void reset_voicing();
        for (int k = 0; k < NUM_CHORDS; k++) chord_note[k] = CHORD_RESET[k];
        fade_dec = FADE_RESET;
        for (int s = 0; s < NUM_STRINGS_DEF; s++) begin
            string_note[s]  = '0;
            string_level[s] = '0;
        end
        cur_zone = int'(ZONE_NONE);
    endfunction

    // work out the messages one accepted item causes and queue them
    function automatic void voice_item(logic op, logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
        int      z;
        t_result r;
        item_msgs.delete();
        if (op == OP_FADE) begin
            for (int s = 0; s < NUM_STRINGS_DEF; s++) begin
                if (string_note[s] != '0 && string_level[s] != '0) begin
                    if (string_level[s] > fade_dec) begin
                        string_level[s] = string_level[s] - fade_dec;
                        push_msg(ST_POLY_AT, string_note[s], string_level[s]);
                    end else begin
                        string_level[s] = '0;
                        push_msg(ST_NOTE_ON, string_note[s], '0);
                    end
                end
            end
        end else if (st[7:4] == MSG_NOTE_ON) begin
            for (int s = 0; s < NUM_STRINGS_DEF; s++) silence_string(s);
        end else if (st[7:4] == MSG_CC && d1 == CC_STRUM) begin
            z = zone_for(d2);
            if (z != cur_zone) begin
                silence_string(z);
                push_msg(ST_NOTE_ON, chord_note[z], VEL_MAX);
                string_note[z]  = chord_note[z];
                string_level[z] = VEL_MAX;
                cur_zone        = z;
            end
        end
        for (int k = 0; k < item_msgs.size(); k++) begin
            r      = item_msgs[k];
            r.last = (k == item_msgs.size() - 1);
            expected_msgs.push_back(r);
        end
    endfunction

    // receiver stall pattern, its character set by the top two bits of rx_phase
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        case (rx_phase[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (rx_phase[2:0] == 3'd0);
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin : check_out
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[7:0];
            got.note   = m_axis_tdata[14:8];
            got.vel    = m_axis_tdata[21:15];
            got.last   = m_axis_tlast;
            if (expected_msgs.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected message: st=%h note=%0d vel=%0d last=%b",
                             got.status, got.note, got.vel, got.last);
            end else begin
                want = expected_msgs.pop_front();
                if (got.status !== want.status || got.note !== want.note ||
                    got.vel !== want.vel || got.last !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("mismatch: exp %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                                 want.status, want.note, want.vel, want.last,
                                 got.status, got.note, got.vel, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_strum_zone_string_voicer: done, errors");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] st, input logic [6:0] d1,
                             input logic [6:0] d2);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, d2, d1, st};
        do @(posedge i_clk); while (!s_axis_tready);
        voice_item(op, st, d1, d2);
    endtask

    task automatic strum(input logic [6:0] value);
        send_item(OP_MIDI, {MSG_CC, 4'($urandom_range(0, 15))}, CC_STRUM, value);
    endtask

    task automatic fade_tick();
        send_item(OP_FADE, 8'($urandom), 7'($urandom), 7'($urandom));
    endtask

    // stop sending and let every outstanding message come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [6:0] val,
                             input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= REG_CHORD_LAST) chord_note[idx] = val;
        else if (idx == REG_FADE) fade_dec = val;
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    task automatic test_defaults();
        strum(7'd0);
        strum(7'd23);
        strum(7'd24);
        strum(7'd0);
        fade_tick();
        send_item(OP_MIDI, 8'h9F, 7'd127, 7'd127);
        fade_tick();
        send_item(OP_MIDI, 8'hB0, 7'd0, 7'd127);
        send_item(OP_MIDI, 8'h00, 7'd1, 7'd0);
        send_item(OP_MIDI, 8'hFF, 7'd1, 7'd127);
    endtask

    task automatic test_zone_edges();
        strum(7'd43);
        strum(7'd44);
        strum(7'd63);
        strum(7'd64);
        strum(7'd83);
        strum(7'd84);
        strum(7'd103);
        strum(7'd104);
        strum(7'd127);
    endtask

    task automatic test_fade_to_silence();
        wait_drain();
        write_reg(REG_FADE, 7'd127, 1'b0);
        fade_tick();
        fade_tick();
        send_item(OP_MIDI, 8'h90, 7'd0, 7'd0);
    endtask

    task automatic test_fade_step_zero();
        wait_drain();
        write_reg(REG_FADE, 7'd0, 1'b0);
        strum(7'd0);
        fade_tick();
    endtask

    task automatic test_chord_note_zero();
        wait_drain();
        write_reg(REG_CHORD_TWO, 7'd0, 1'b0);
        strum(7'd50);
        fade_tick();
        send_item(OP_MIDI, 8'h95, 7'd60, 7'd64);
    endtask

    task automatic test_register_extremes();
        wait_drain();
        for (int k = 0; k < NUM_CHORDS; k++)
            write_reg(CFG_IW'(k), (k % 2 == 0) ? 7'd127 : 7'd1, 1'b1);
        write_reg(REG_SPARE, 7'($urandom), 1'b1);
        write_reg(REG_FADE, 7'd1, 1'b0);
    endtask

    task automatic test_random_voicing();
        wait_drain();
        for (int k = 0; k < NUM_CHORDS; k++)
            write_reg(CFG_IW'(k), ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127)),
                      1'b1);
        write_reg(REG_FADE, 7'($urandom_range(1, 12)), 1'b0);
    endtask

    task automatic test_random_play(input int count, input int pause_at);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) wait_drain();
            pick = $urandom_range(0, 99);
            if (pick < 40)
                strum(7'($urandom));
            else if (pick < 70)
                fade_tick();
            else if (pick < 80)
                send_item(OP_MIDI, {MSG_NOTE_ON, 4'($urandom)}, 7'($urandom), 7'($urandom));
            else
                send_item(OP_MIDI, 8'($urandom), 7'($urandom), 7'($urandom));
        end
    endtask

    initial begin
        reset_voicing();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_zone_edges();
        test_fade_to_silence();
        test_fade_step_zero();
        test_chord_note_zero();
        test_random_play(140, 70);
        test_random_voicing();
        test_random_play(140, -1);
        test_register_extremes();
        test_random_play(100, -1);
        wait_drain();
        write_reg(REG_FADE, 7'd127, 1'b0);
        test_random_play(40, -1);
        wait_drain();
        if (mismatch_cnt == 0) begin
            $display("tb_strum_zone_string_voicer: done, clean");
        end else begin
            $display("tb_strum_zone_string_voicer: done, errors");
        end
        $finish;
    end

endmodule
